[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ant, cons, msg)
`define ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

[hw/rtl/wvps_pkg.sv]
// Shared types and constants for the windowed VWAP pivot score block.
package wvps_pkg;
  localparam int WIN_MAX    = 256;
  localparam int ADDR_W     = $clog2(WIN_MAX);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int PRICE_W    = 32;
  localparam int VOL_W      = 24;
  localparam int FRAC_BITS  = 16;
  localparam int SCORE_W    = 16;
  localparam int DIV_N_W    = 64;
  localparam int DIV_D_W    = PRICE_W + 2;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W) + 1;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 16'd40960;
  localparam logic [CNT_W-1:0]   WIN_RESET  = 9'd96;

  // divide by 3: x * (2^35+1)/3 >> 35, multiplier split in two 17-bit halves
  localparam int D3_X_W = PRICE_W + 2;
  localparam int D3_M_W = 17;
  localparam int D3_P_W = D3_X_W + D3_M_W;
  localparam logic [D3_M_W-1:0] D3_M_LO = 17'h0AAAB;
  localparam logic [D3_M_W-1:0] D3_M_HI = 17'h15555;

  typedef struct packed {
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] typical;
    logic [VOL_W-1:0]   volume;
  } bar_entry_t;
endpackage

[hw/rtl/wvps_div.sv]
// Restoring divider, one quotient bit per cycle.
module wvps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  wvps_pkg::div_req_t         req,
  output logic                       done,
  output logic [wvps_pkg::DIV_N_W-1:0] quotient
);
  import wvps_pkg::*;
  `include "assert_macros.svh"

  logic [DIV_N_W-1:0]   q_r;
  logic [DIV_D_W-1:0]   d_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_D_W:0]     shifted;
  logic                 fits;

  assign shifted = {rem_r, q_r[DIV_N_W-1]};
  assign fits    = shifted >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        rem_r <= fits ? DIV_D_W'(shifted - {1'b0, d_r}) : DIV_D_W'(shifted);
        q_r   <= {q_r[DIV_N_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  `ASSERT_NEXT(a_done_single, done_r, !done_r, "divider done held two cycles")
  `ASSERT_IMPLIES(a_cnt_busy, busy_r, cnt_r != '0, "divider busy with zero count")
  `ASSERT_NEXT(a_start_busy, start, busy_r, "divider did not start")
endmodule

[hw/rtl/windowed_vwap_pivot_score.sv]
// Per bar (n = effective window length): divide by 3 (reciprocal multiply) for the typical
// price, the walk over n bars (one memory read per cycle), a serial division for the VWAP
// (skipped when the window holds no volume), a second divide by 3 for the pivot and a serial
// division for the score. Fewer than three bars stored: bar written, result 0 with no walk.
// Throughput: one bar at a time; a finished result may wait in the output register while the
// next bar is taken. Reset (rst_n low, synchronous): bar count and write slot cleared, window
// length back to 96; sums cleared per walk; bar memory not cleared (read after write).
module windowed_vwap_pivot_score (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [119:0]            in_tdata,  // bar_high, bar_low, bar_close, bar_volume
  input  logic                    in_tuser,  // replaces_last
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata, // score_size
  output logic                    out_tuser, // score_valid
  input  logic                    cfg_we,
  input  logic [wvps_pkg::CNT_W-1:0] cfg_wdata
);
  import wvps_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_TYP, S_WRITE, S_WALK, S_VWAP, S_PIV, S_SCORE, S_OUT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     win_len_r;
  logic [CNT_W-1:0]     bars_r;
  logic [ADDR_W-1:0]    wslot_r;
  logic [ADDR_W-1:0]    slot_r;
  logic [PRICE_W-1:0]   high_r, low_r, close_r, typ_r;
  logic [VOL_W-1:0]     vol_r;
  logic                 valid_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     iss_r;
  logic [ADDR_W-1:0]    rd_addr_r;
  logic                 rd_v_r, prod_v_r;
  bar_entry_t           mem_q_r;
  logic [55:0]          prod_r;
  logic [VOL_W-1:0]     pvol_r;
  logic [DIV_N_W-1:0]   ws_r;
  logic [32:0]          vs_r;
  logic [PRICE_W-1:0]   hmax_r, lmin_r, vwap_r;
  logic                 div_start_r;
  div_req_t             div_req_r;
  logic                 out_tvalid_r;
  logic [SCORE_W-1:0]   out_score_r;
  logic                 out_sv_r;
  logic                 d3_start_r;
  logic [D3_X_W-1:0]    d3_x_r;
  logic [1:0]           d3_ph_r;
  logic [D3_P_W-1:0]    d3_lo_r;
  logic [PRICE_W-1:0]   d3_q_r;
  logic                 d3_done_r;

  bar_entry_t           mem [WIN_MAX];

  logic                 div_done;
  logic [DIV_N_W-1:0]   div_q;
  logic                 revise;
  logic [ADDR_W-1:0]    slot_nxt;
  logic [ADDR_W-1:0]    wslot_nxt;
  logic [CNT_W-1:0]     bars_nxt;
  logic [CNT_W-1:0]     wl_clamp;
  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     n_nxt;
  logic                 issue;
  logic [PRICE_W-1:0]   d_vwap, d_piv;
  logic [DIV_D_W-1:0]   denom;
  logic [PRICE_W+1:0]   sum3_in, sum3_piv;
  logic [D3_M_W-1:0]    d3_mul;
  logic [D3_P_W-1:0]    d3_prod;
  logic [D3_P_W:0]      d3_sum;

  wvps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .req      (div_req_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // slot selection and window clamp for the incoming bar
  always_comb begin
    revise    = in_tuser && (bars_r != '0);
    slot_nxt  = revise ? ADDR_W'(wslot_r - 1'b1) : wslot_r;
    wslot_nxt = revise ? wslot_r : ADDR_W'(wslot_r + 1'b1);
    bars_nxt  = (revise || bars_r == CNT_W'(WIN_MAX + 1)) ? bars_r : CNT_W'(bars_r + 1'b1);
    wl_clamp  = (win_len_r == '0) ? CNT_W'(1) :
                (win_len_r > CNT_W'(WIN_MAX)) ? CNT_W'(WIN_MAX) : win_len_r;
    lim       = CNT_W'(bars_nxt - 1'b1);
    n_nxt     = (wl_clamp > lim) ? lim : wl_clamp;
    sum3_in   = (PRICE_W+2)'(in_tdata[31:0]) + (PRICE_W+2)'(in_tdata[63:32])
              + (PRICE_W+2)'(in_tdata[95:64]);
    sum3_piv  = (PRICE_W+2)'(hmax_r) + (PRICE_W+2)'(lmin_r) + (PRICE_W+2)'(close_r);
    issue     = (state_r == S_WALK) && (iss_r != n_r);
    d_vwap    = (close_r >= vwap_r) ? close_r - vwap_r : vwap_r - close_r;
    d_piv     = (close_r >= d3_q_r) ? close_r - d3_q_r : d3_q_r - close_r;
    denom     = DIV_D_W'(1 << FRAC_BITS) + DIV_D_W'(d_vwap) + DIV_D_W'(d_piv);
    // low half of the reciprocal first, high half in the next cycle
    d3_mul    = d3_ph_r[1] ? D3_M_HI : D3_M_LO;
    d3_prod   = D3_P_W'(d3_x_r) * D3_P_W'(d3_mul);
    d3_sum    = (D3_P_W+1)'(d3_prod) + (D3_P_W+1)'(d3_lo_r >> D3_M_W);
  end

  // divide by 3: start -> low product -> high product and quotient, then done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_ph_r   <= '0;
      d3_done_r <= 1'b0;
    end else begin
      d3_ph_r   <= {d3_ph_r[0], d3_start_r};
      d3_done_r <= d3_ph_r[1];
      if (d3_ph_r[0]) d3_lo_r <= d3_prod;
      if (d3_ph_r[1]) d3_q_r <= d3_sum[D3_M_W+1 +: PRICE_W];
    end
  end

  // bar memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      mem[slot_r] <= '{high: high_r, low: low_r, typical: typ_r, volume: vol_r};
    end
    mem_q_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_len_r    <= WIN_RESET;
      bars_r       <= '0;
      wslot_r      <= '0;
      rd_v_r       <= 1'b0;
      prod_v_r     <= 1'b0;
      div_start_r  <= 1'b0;
      d3_start_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      d3_start_r  <= 1'b0;
      rd_v_r      <= issue;
      prod_v_r    <= rd_v_r;
      if (cfg_we) win_len_r <= cfg_wdata;
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      // walk pipeline: data stage then product stage
      if (rd_v_r) begin
        if (mem_q_r.high > hmax_r) hmax_r <= mem_q_r.high;
        if (mem_q_r.low < lmin_r) lmin_r <= mem_q_r.low;
        prod_r <= 56'(mem_q_r.typical) * 56'(mem_q_r.volume);
        pvol_r <= mem_q_r.volume;
      end
      if (prod_v_r) begin
        ws_r <= ws_r + DIV_N_W'(prod_r);
        vs_r <= vs_r + 33'(pvol_r);
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            high_r     <= in_tdata[31:0];
            low_r      <= in_tdata[63:32];
            close_r    <= in_tdata[95:64];
            vol_r      <= in_tdata[119:96];
            slot_r     <= slot_nxt;
            wslot_r    <= wslot_nxt;
            bars_r     <= bars_nxt;
            valid_r    <= bars_nxt >= CNT_W'(3);
            n_r        <= n_nxt;
            d3_x_r     <= sum3_in;
            d3_start_r <= 1'b1;
            state_r    <= S_TYP;
          end
        end
        S_TYP: begin
          if (d3_done_r) begin
            typ_r   <= d3_q_r;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          ws_r      <= '0;
          vs_r      <= '0;
          hmax_r    <= '0;
          lmin_r    <= '1;
          iss_r     <= '0;
          rd_addr_r <= slot_r;
          if (valid_r) begin
            state_r <= S_WALK;
          end else begin
            out_score_r <= '0;
            state_r     <= S_OUT;
          end
        end
        S_WALK: begin
          if (issue) begin
            rd_addr_r <= rd_addr_r - 1'b1;
            iss_r     <= iss_r + 1'b1;
          end else if (!rd_v_r && !prod_v_r) begin
            if (vs_r != '0) begin
              div_start_r <= 1'b1;
              div_req_r   <= '{dividend: ws_r, divisor: DIV_D_W'(vs_r)};
              state_r     <= S_VWAP;
            end else begin
              vwap_r     <= close_r;
              d3_x_r     <= sum3_piv;
              d3_start_r <= 1'b1;
              state_r    <= S_PIV;
            end
          end
        end
        S_VWAP: begin
          if (div_done) begin
            vwap_r     <= div_q[PRICE_W-1:0];
            d3_x_r     <= sum3_piv;
            d3_start_r <= 1'b1;
            state_r    <= S_PIV;
          end
        end
        S_PIV: begin
          if (d3_done_r) begin
            div_req_r   <= '{dividend: DIV_N_W'(64'd10 << (FRAC_BITS + 12)), divisor: denom};
            div_start_r <= 1'b1;
            state_r     <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (div_done) begin
            out_score_r <= (div_q > DIV_N_W'(SCORE_MAX)) ? SCORE_MAX : div_q[SCORE_W-1:0];
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_sv_r     <= valid_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [SCORE_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_tvalid_r || out_tready)) out_data_r <= out_score_r;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sv_r;

  `ASSERT_IMPLIES(a_walk_bound, state_r == S_WALK, iss_r <= n_r, "walk issued past window")
  `ASSERT_IMPLIES(a_prod_follows, prod_v_r, $past(rd_v_r), "product stage without read")
  `ASSERT_IMPLIES(a_invalid_zero, out_tvalid_r && !out_sv_r, out_data_r == '0,
                  "score nonzero without valid")
  `ASSERT_IMPLIES(a_score_max, out_tvalid_r, out_data_r <= SCORE_MAX, "score above max")
endmodule

[dv/tb.sv]
// Testbench for the windowed VWAP pivot score block: table-driven and random bars.
`timescale 1ns / 100ps

module tb;
  import wvps_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  windowed_vwap_pivot_score DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [15:0] score;
    logic        valid;
  } score_t;

  typedef struct {
    logic [31:0] hi, lo, cl;
    logic [23:0] vol;
    logic        revise;
    logic        has_exp;
    score_t      exp;
  } bar_row_t;

  // predictor state
  logic [31:0] m_high[WIN_MAX];
  logic [31:0] m_low[WIN_MAX];
  logic [31:0] m_typ[WIN_MAX];
  logic [23:0] m_vol[WIN_MAX];
  int unsigned m_seen, m_slot, m_win;

  score_t score_q[$];
  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_long = 0;

  function automatic logic [63:0] absd(logic [63:0] a, logic [63:0] b);
    return a >= b ? a - b : b - a;
  endfunction

  function automatic score_t predict_score(bar_row_t r);
    score_t s;
    int unsigned slot, n, idx;
    logic [63:0] wsum, prod, hmax, lmin, vwap, pivot, denom, q;
    logic [32:0] vsum;
    s = '0;
    if (r.revise && m_seen > 0) slot = (m_slot + WIN_MAX - 1) % WIN_MAX;
    else begin
      slot = m_slot;
      m_slot = (slot + 1) % WIN_MAX;
      if (m_seen < WIN_MAX + 1) m_seen++;
    end
    m_high[slot] = r.hi;
    m_low[slot] = r.lo;
    m_typ[slot] = 32'(({32'd0, r.hi} + r.lo + r.cl) / 3);
    m_vol[slot] = r.vol;
    if (m_seen >= 3) begin
      n = (m_win == 0) ? 1 : m_win;
      if (n > WIN_MAX) n = WIN_MAX;
      if (n > m_seen - 1) n = m_seen - 1;
      wsum = 0; vsum = 0; hmax = 0; lmin = 64'hFFFF_FFFF; idx = slot;
      for (int i = 0; i < n; i++) begin
        prod = 64'(m_typ[idx]) * m_vol[idx];
        wsum = (wsum > ~prod) ? '1 : wsum + prod;
        vsum = vsum + m_vol[idx];
        if (m_high[idx] > hmax) hmax = 64'(m_high[idx]);
        if (m_low[idx] < lmin) lmin = 64'(m_low[idx]);
        idx = (idx + WIN_MAX - 1) % WIN_MAX;
      end
      vwap = (vsum != 0) ? wsum / vsum : 64'(r.cl);
      pivot = (hmax + lmin + r.cl) / 3;
      denom = (64'd1 << FRAC_BITS) + absd(r.cl, vwap) + absd(r.cl, pivot);
      q = (64'd10 << (FRAC_BITS + 12)) / denom;
      s.score = (q > SCORE_MAX) ? SCORE_MAX : q[15:0];
      s.valid = 1'b1;
    end
    return s;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
  endfunction

  task automatic send_bar(bar_row_t r);
    score_t p;
    int g;
    p = predict_score(r);
    if (r.has_exp && p != r.exp) begin
      $display("table row disagrees with predictor: %h vs %h", r.exp, p);
      errors++;
    end
    score_q.push_back(r.has_exp ? r.exp : p);
    g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    // valid drops between requests
    repeat (g + 1) @(posedge clk);
    in_tdata <= {r.vol, r.cl, r.lo, r.hi};
    in_tuser <= r.revise;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (score_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_window(int unsigned v);
    cfg_wdata <= v[CNT_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_win = v & 9'h1FF;
  endtask

  function automatic bar_row_t rand_bar(bit rev_ok);
    bar_row_t r;
    logic [31:0] base;
    base = $urandom_range(0, 3) == 0 ? $urandom() : 32'h0064_0000 + $urandom_range(0, 32'h0040_0000);
    r.lo = ($urandom_range(0, 9) == 0) ? $urandom() : base;
    r.hi = ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 32'h0008_0000);
    r.cl = ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 5))
      0: r.vol = 0;
      1: r.vol = 24'hFFFFFF;
      default: r.vol = 24'($urandom());
    endcase
    r.revise = rev_ok && ($urandom_range(0, 5) == 0);
    r.has_exp = 0;
    r.exp = '0;
    return r;
  endfunction

  // receiver with random stalls
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g != 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (score_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h/%b", out_tdata, out_tuser);
      end else begin
        score_t e;
        e = score_q.pop_front();
        if (e.score !== out_tdata || e.valid !== out_tuser) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp score %0d valid %b, got %0d %b",
                     e.score, e.valid, out_tdata, out_tuser);
        end
      end
    end
  end

  // watchdog on cycles with no input or output handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  bar_row_t dir_rows[$];

  function automatic bar_row_t mk(logic [31:0] h, logic [31:0] l, logic [31:0] c,
                                  logic [23:0] v, logic rv, logic he, score_t ex);
    bar_row_t r;
    r.hi = h; r.lo = l; r.cl = c; r.vol = v; r.revise = rv; r.has_exp = he; r.exp = ex;
    return r;
  endfunction

  initial begin
    int k;
    int win_vals[5];
    win_vals = '{0, 1, 256, 511, 2};
    m_seen = 0; m_slot = 0; m_win = 96;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // revision with no bar stored appends; first two bars give no score
    dir_rows.push_back(mk('1, '1, '1, 24'hFFFFFF, 1, 1, '0));
    dir_rows.push_back(mk(0, 0, 0, 0, 0, 1, '0));
    // flat prices: distance zero, score clips to 10.0
    dir_rows.push_back(mk(0, 0, 0, 0, 0, 1, {SCORE_MAX, 1'b1}));
    dir_rows.push_back(mk(0, 0, 0, 24'hFFFFFF, 1, 1, {SCORE_MAX, 1'b1}));
    dir_rows.push_back(mk('1, 0, '1, 24'hFFFFFF, 0, 0, '0));
    dir_rows.push_back(mk('1, '1, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0, 0, '0));
    dir_rows.push_back(mk('1, 0, 32'h8000_0000, 24'hFFFFFF, 1, 0, '0));
    dir_rows.push_back(mk(32'h0064_8000, 32'h0063_0000, 32'h0064_0000, 500, 0, 0, '0));
    dir_rows.push_back(mk(32'h0065_0000, 32'h0064_0000, 32'h0064_C000, 0, 0, 0, '0));
    foreach (dir_rows[i]) send_bar(dir_rows[i]);
    drain();

    // window extremes: zero, one, full, above max, then two
    foreach (win_vals[i]) begin
      write_window(win_vals[i]);
      repeat (4) send_bar(rand_bar(1));
      drain();
    end

    // fill pressure: receiver holds off while bars keep coming
    hold_long = 1;
    repeat (12) send_bar(rand_bar(1));
    drain();

    k = 0;
    while (k < 390) begin
      if (k % 80 == 0) begin
        drain();
        write_window(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) :
                     $urandom_range(1, 24));
      end
      send_bar(rand_bar(1));
      k++;
    end
    drain();
    write_window(256);
    repeat (20) send_bar(rand_bar(1));
    drain();

    if (errors == 0 && score_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[windowed_vwap_pivot_score.f]
+incdir+hw/rtl
hw/rtl/wvps_pkg.sv
hw/rtl/wvps_div.sv
hw/rtl/windowed_vwap_pivot_score.sv
dv/tb.sv
